### hw/rtl/wlom_pkg.sv
// Shared types and constants for the window layer order manager.
package wlom_pkg;

  localparam int WLOM_LAYER_COUNT = 16;

  localparam logic [11:0] SCREEN_MAX   = 12'd2048;
  localparam logic [11:0] WIDTH_RESET  = 12'd320;
  localparam logic [11:0] HEIGHT_RESET = 12'd200;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_SIZE  = 3'd1,
    CMD_LEVEL = 3'd2,
    CMD_SLIDE = 3'd3,
    CMD_FREE  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REMOVE,
    ST_INS_CHECK,
    ST_INSERT,
    ST_SET_LVL,
    ST_RENUM,
    ST_DMG_A,
    ST_MOVE,
    ST_DMG_B,
    ST_EMIT_A,
    ST_EMIT_B,
    ST_EMIT_N
  } state_t;

  typedef struct packed {
    logic [11:0] x0;
    logic [11:0] y0;
    logic [11:0] x1;
    logic [11:0] y1;
  } rect_t;

  typedef struct packed {
    logic latch;
    logic decode;
    logic do_alloc;
    logic do_size;
    logic do_move;
    logic do_free_clr;
    logic lv_start;
    logic lv_hide;
    logic rem_step;
    logic rem_end;
    logic ins_init;
    logic ins_step;
    logic ins_place;
    logic ins_fail;
    logic lv_write;
    logic ren_step;
    logic dmg_a;
    logic dmg_b;
    logic load_a;
    logic load_b;
    logic load_n;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       lay_ok;
    logic       shown;
    logic       lv_same;
    logic       rem_more;
    logic       ins_ok;
    logic       ins_more;
    logic       ren_more;
    logic       a_ok;
    logic       b_ok;
    logic       can_load;
  } dp_stat_t;

endpackage

### hw/rtl/window_layer_order_manager.sv
// Top level: screen size registers, sequencer and layer datapath.
// One command at a time; the next is taken the cycle after its last beat is loaded.
// A command that changes no stacking level is decoded and then gives its single beat once the
// output can take it; a slide of a shown layer clips the old rectangle, moves, clips the new
// one and gives its beats. A level change or free of a shown layer shifts and renumbers one
// slot a cycle. Reset frees all layers and sets the screen to 320x200.
module window_layer_order_manager import wlom_pkg::*; #(
  parameter int LAYER_COUNT = WLOM_LAYER_COUNT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic [3:0]         in_layer,
  input  logic signed [11:0] in_pos_x,
  input  logic signed [11:0] in_pos_y,
  input  logic [10:0]        in_size_w,
  input  logic [10:0]        in_size_h,
  input  logic signed [5:0]  in_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [3:0]         out_layer_id,
  output logic               out_rect_valid,
  output logic [11:0]        out_rect_x0,
  output logic [11:0]        out_rect_y0,
  output logic [11:0]        out_rect_x1,
  output logic [11:0]        out_rect_y1,
  output logic               out_last
);

  logic [11:0] screen_w_r, screen_h_r;
  logic [11:0] wr_val;
  logic        wr_en;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_val = (pwdata[11:0] > SCREEN_MAX) ? SCREEN_MAX : pwdata[11:0];
  assign prdata = {20'd0, (paddr[2] == REG_HEIGHT) ? screen_h_r : screen_w_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_w_r <= WIDTH_RESET;
      screen_h_r <= HEIGHT_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_WIDTH) begin
        screen_w_r <= wr_val;
      end else begin
        screen_h_r <= wr_val;
      end
    end
  end

  wlom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wlom_dp #(
    .LAYER_COUNT (LAYER_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_command     (in_command),
    .in_layer       (in_layer),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_size_w      (in_size_w),
    .in_size_h      (in_size_h),
    .in_level       (in_level),
    .screen_w       (screen_w_r),
    .screen_h       (screen_h_r),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_layer_id   (out_layer_id),
    .out_rect_valid (out_rect_valid),
    .out_rect_x0    (out_rect_x0),
    .out_rect_y0    (out_rect_y0),
    .out_rect_x1    (out_rect_x1),
    .out_rect_y1    (out_rect_y1),
    .out_last       (out_last)
  );

endmodule

### hw/rtl/wlom_ctrl.sv
// Command sequencer for the window layer order manager.
module wlom_ctrl import wlom_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = ST_EMIT_N;
        if (stat.cmd == CMD_ALLOC) begin
          cmd.do_alloc = 1'b1;
        end else if (stat.lay_ok) begin
          if (stat.cmd == CMD_SIZE) begin
            cmd.do_size = 1'b1;
          end else if (stat.cmd == CMD_LEVEL) begin
            if (!stat.lv_same) begin
              cmd.lv_start = 1'b1;
              state_nxt    = stat.shown ? ST_REMOVE : ST_INS_CHECK;
            end
          end else if (stat.cmd == CMD_SLIDE) begin
            if (stat.shown) begin
              state_nxt = ST_DMG_A;
            end else begin
              cmd.do_move = 1'b1;
            end
          end else if (stat.cmd == CMD_FREE) begin
            if (stat.shown) begin
              cmd.lv_start = 1'b1;
              cmd.lv_hide  = 1'b1;
              state_nxt    = ST_REMOVE;
            end else begin
              cmd.do_free_clr = 1'b1;
            end
          end
        end
      end
      ST_REMOVE: begin
        if (stat.rem_more) begin
          cmd.rem_step = 1'b1;
        end else begin
          cmd.rem_end = 1'b1;
          state_nxt   = ST_INS_CHECK;
        end
      end
      ST_INS_CHECK: begin
        if (stat.ins_ok) begin
          cmd.ins_init = 1'b1;
          state_nxt    = ST_INSERT;
        end else begin
          cmd.ins_fail = 1'b1;
          state_nxt    = ST_SET_LVL;
        end
      end
      ST_INSERT: begin
        if (stat.ins_more) begin
          cmd.ins_step = 1'b1;
        end else begin
          cmd.ins_place = 1'b1;
          state_nxt     = ST_SET_LVL;
        end
      end
      ST_SET_LVL: begin
        cmd.lv_write = 1'b1;
        state_nxt    = ST_RENUM;
      end
      ST_RENUM: begin
        if (stat.ren_more) begin
          cmd.ren_step = 1'b1;
        end else begin
          state_nxt = ST_DMG_A;
        end
      end
      ST_DMG_A: begin
        cmd.dmg_a = 1'b1;
        if (stat.cmd == CMD_FREE) begin
          cmd.do_free_clr = 1'b1;
        end
        state_nxt = (stat.cmd == CMD_SLIDE) ? ST_MOVE : ST_EMIT_A;
      end
      ST_MOVE: begin
        cmd.do_move = 1'b1;
        state_nxt   = ST_DMG_B;
      end
      ST_DMG_B: begin
        cmd.dmg_b = 1'b1;
        state_nxt = ST_EMIT_A;
      end
      ST_EMIT_A: begin
        if (stat.can_load) begin
          if (stat.a_ok) begin
            cmd.load_a = 1'b1;
            state_nxt  = stat.b_ok ? ST_EMIT_B : ST_IDLE;
          end else if (stat.b_ok) begin
            cmd.load_b = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.load_n = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      ST_EMIT_B: begin
        if (stat.can_load) begin
          cmd.load_b = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_EMIT_N: begin
        if (stat.can_load) begin
          cmd.load_n = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/wlom_dp.sv
// Layer tables, order table, clip unit and result register.
module wlom_dp import wlom_pkg::*; #(
  parameter int LAYER_COUNT = WLOM_LAYER_COUNT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_command,
  input  logic [3:0]         in_layer,
  input  logic signed [11:0] in_pos_x,
  input  logic signed [11:0] in_pos_y,
  input  logic [10:0]        in_size_w,
  input  logic [10:0]        in_size_h,
  input  logic signed [5:0]  in_level,
  input  logic [11:0]        screen_w,
  input  logic [11:0]        screen_h,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [3:0]         out_layer_id,
  output logic               out_rect_valid,
  output logic [11:0]        out_rect_x0,
  output logic [11:0]        out_rect_y0,
  output logic [11:0]        out_rect_x1,
  output logic [11:0]        out_rect_y1,
  output logic               out_last
);

  localparam int LW  = $clog2(LAYER_COUNT);
  localparam int LVW = LW + 2;
  localparam int CW  = (LVW > 6) ? LVW : 6;
  localparam int AL  = (LAYER_COUNT < 16) ? LAYER_COUNT : 16;

  logic [2:0]         cmd_r;
  logic [3:0]         lay_r;
  logic signed [11:0] px_r, py_r;
  logic [10:0]        w_in_r, h_in_r;
  logic signed [5:0]  lv_r;

  logic                  in_use_r [LAYER_COUNT];
  logic signed [LVW-1:0] level_r  [LAYER_COUNT];
  logic signed [11:0]    pos_l_r  [LAYER_COUNT];
  logic signed [11:0]    pos_t_r  [LAYER_COUNT];
  logic [10:0]           size_w_r [LAYER_COUNT];
  logic [10:0]           size_h_r [LAYER_COUNT];
  logic [LW-1:0]         order_r  [LAYER_COUNT];

  logic signed [LVW-1:0] top_lvl_r;
  logic signed [LVW-1:0] h_r;
  logic signed [LVW-1:0] req_r;
  logic                  res_status_r;
  logic [3:0]            res_id_r;
  rect_t                 ra_r, rb_r;
  logic                  a_ok_r, b_ok_r;

  logic                  out_valid_r, out_status_r, out_rect_valid_r, out_last_r;
  logic [3:0]            out_layer_id_r;
  rect_t                 out_rect_r;

  logic [LW-1:0]         li;
  logic [LW-1:0]         h_idx, hp1_idx;
  logic signed [LVW-1:0] hp1;
  logic                  found;
  logic [3:0]            fidx;
  logic signed [CW-1:0]  old_w, lv_w, top_w, hi_w, req_c;
  logic signed [LVW:0]   top_p1;
  logic signed [13:0]    lx, rx, ty, by, sw14, sh14, x0c, x1c, y0c, y1c;
  logic                  clip_ok;
  rect_t                 clip_rect;

  assign li      = LW'(lay_r);
  assign hp1     = h_r + LVW'(1);
  assign h_idx   = h_r[LW-1:0];
  assign hp1_idx = hp1[LW-1:0];

  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int k = AL - 1; k >= 0; k--) begin
      if (!in_use_r[k]) begin
        found = 1'b1;
        fidx  = 4'(k);
      end
    end
  end

  always_comb begin
    old_w = CW'(level_r[li]);
    lv_w  = CW'(lv_r);
    top_w = CW'(top_lvl_r);
    hi_w  = level_r[li][LVW-1] ? top_w + CW'(1) : top_w;
    req_c = lv_w;
    if (req_c > hi_w) begin
      req_c = hi_w;
    end
    if (req_c < $signed({CW{1'b1}})) begin
      req_c = '1;
    end
  end

  assign top_p1 = (LVW+1)'(top_lvl_r) + (LVW+1)'(1);

  always_comb begin
    lx   = 14'(pos_l_r[li]);
    ty   = 14'(pos_t_r[li]);
    rx   = lx + $signed({3'b000, size_w_r[li]});
    by   = ty + $signed({3'b000, size_h_r[li]});
    sw14 = $signed({2'b00, screen_w});
    sh14 = $signed({2'b00, screen_h});
    x0c  = lx[13] ? '0 : lx;
    y0c  = ty[13] ? '0 : ty;
    x1c  = (rx > sw14) ? sw14 : rx;
    y1c  = (by > sh14) ? sh14 : by;
    clip_ok      = (x1c > x0c) && (y1c > y0c);
    clip_rect.x0 = x0c[11:0];
    clip_rect.y0 = y0c[11:0];
    clip_rect.x1 = x1c[11:0];
    clip_rect.y1 = y1c[11:0];
  end

  always_comb begin
    stat.cmd      = cmd_r;
    stat.lay_ok   = (32'(lay_r) < LAYER_COUNT) && in_use_r[li];
    stat.shown    = !level_r[li][LVW-1];
    stat.lv_same  = (req_c == old_w);
    stat.rem_more = (h_r < top_lvl_r);
    stat.ins_ok   = !req_r[LVW-1] && (top_p1 < (LVW+1)'(LAYER_COUNT));
    stat.ins_more = (h_r >= req_r);
    stat.ren_more = (h_r <= top_lvl_r);
    stat.a_ok     = a_ok_r;
    stat.b_ok     = b_ok_r;
    stat.can_load = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_command;
      lay_r  <= in_layer;
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      w_in_r <= in_size_w;
      h_in_r <= in_size_h;
      lv_r   <= in_level;
    end
    if (cmd.decode) begin
      if (cmd_r == CMD_ALLOC) begin
        res_status_r <= !found;
        res_id_r     <= found ? fidx : 4'd0;
      end else begin
        res_status_r <= 1'b0;
        res_id_r     <= lay_r;
      end
    end
    if (cmd.lv_start) begin
      req_r <= cmd.lv_hide ? '1 : LVW'(req_c);
      h_r   <= level_r[li];
    end else if (cmd.rem_step || cmd.ren_step) begin
      h_r <= hp1;
    end else if (cmd.ins_init) begin
      h_r <= top_lvl_r;
    end else if (cmd.ins_step) begin
      h_r <= h_r - LVW'(1);
    end else if (cmd.lv_write) begin
      h_r <= '0;
    end
    if (cmd.ins_fail) begin
      req_r <= '1;
    end
    if (cmd.rem_step) begin
      order_r[h_idx] <= order_r[hp1_idx];
    end else if (cmd.ins_step) begin
      order_r[hp1_idx] <= order_r[h_idx];
    end else if (cmd.ins_place) begin
      order_r[req_r[LW-1:0]] <= li;
    end
    if (cmd.do_alloc && found) begin
      level_r[LW'(fidx)] <= '1;
    end else if (cmd.lv_write) begin
      level_r[li] <= req_r;
    end else if (cmd.ren_step) begin
      level_r[order_r[h_idx]] <= h_r;
    end
    if (cmd.dmg_a) begin
      ra_r   <= clip_rect;
      a_ok_r <= clip_ok;
      b_ok_r <= 1'b0;
    end else if (cmd.dmg_b) begin
      rb_r   <= clip_rect;
      b_ok_r <= clip_ok;
    end
    if (cmd.load_a) begin
      out_rect_r <= ra_r;
    end else if (cmd.load_b) begin
      out_rect_r <= rb_r;
    end else if (cmd.load_n) begin
      out_rect_r <= '0;
    end
    if (cmd.load_a || cmd.load_b || cmd.load_n) begin
      out_status_r     <= cmd.load_n ? res_status_r : 1'b0;
      out_layer_id_r   <= res_id_r;
      out_rect_valid_r <= !cmd.load_n;
      out_last_r       <= !cmd.load_a || !b_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAYER_COUNT; k++) begin
        in_use_r[k] <= 1'b0;
        pos_l_r[k]  <= '0;
        pos_t_r[k]  <= '0;
        size_w_r[k] <= '0;
        size_h_r[k] <= '0;
      end
      top_lvl_r   <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.do_alloc && found) begin
        in_use_r[LW'(fidx)] <= 1'b1;
      end else if (cmd.do_free_clr) begin
        in_use_r[li] <= 1'b0;
      end
      if (cmd.do_size) begin
        size_w_r[li] <= w_in_r;
        size_h_r[li] <= h_in_r;
      end
      if (cmd.do_move) begin
        pos_l_r[li] <= px_r;
        pos_t_r[li] <= py_r;
      end
      if (cmd.rem_end) begin
        top_lvl_r <= top_lvl_r - LVW'(1);
      end else if (cmd.ins_place) begin
        top_lvl_r <= top_lvl_r + LVW'(1);
      end
      if (cmd.load_a || cmd.load_b || cmd.load_n) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_layer_id   = out_layer_id_r;
  assign out_rect_valid = out_rect_valid_r;
  assign out_rect_x0    = out_rect_r.x0;
  assign out_rect_y0    = out_rect_r.y0;
  assign out_rect_x1    = out_rect_r.x1;
  assign out_rect_y1    = out_rect_r.y1;
  assign out_last       = out_last_r;

endmodule
